FILE: rtl/bpc_pkg.sv
// Shared types, widths and constants of the barometric compensation pipeline.
package bpc_pkg;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int TDIV_NUM_W  = 27;
   localparam int TDIV_DEN_W  = 20;
   localparam int PDIV_NUM_W  = 32;
   localparam int PDIV_DEN_W  = 17;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COEFFS_A = 2'd0,
      CSR_COEFFS_B = 2'd1,
      CSR_COEFFS_C = 2'd2
   } csr_index_type;

   localparam logic signed [28:0] T_ROUND     = 29'sd8;
   localparam logic signed [28:0] B6_OFFSET   = 29'sd4000;
   localparam logic        [31:0] B4_OFFSET   = 32'd32768;
   localparam logic        [15:0] B7_SCALE    = 16'd50000;
   localparam logic signed [59:0] PSQ_GAIN    = 60'sd3038;
   localparam logic signed [45:0] PLIN_GAIN   = -46'sd7357;
   localparam logic signed [45:0] PRES_OFFSET = 46'sd3791;
   localparam logic signed [24:0] T_MAX       = 25'sd32767;
   localparam logic signed [24:0] T_MIN       = -25'sd32768;
   localparam logic signed [45:0] P_MAX       = 46'sd262143;

   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic        [15:0] ac4;
      logic        [15:0] ac5;
      logic        [15:0] ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
   } coeff_type;

   typedef struct packed {
      logic signed [18:0] x1;
      logic        [23:0] up;
      logic        [1:0]  oss;
      logic               neg;
      logic               err;
   } tside_type;

   typedef struct packed {
      logic signed [15:0] t;
      logic               hi;
      logic               err;
   } pside_type;

   typedef struct packed {
      logic                  valid;
      logic [TDIV_NUM_W-1:0] num;
      logic [TDIV_DEN_W-1:0] den;
      tside_type             side;
   } tdiv_req_type;

   typedef struct packed {
      logic                  valid;
      logic [TDIV_NUM_W-1:0] quo;
      tside_type             side;
   } tdiv_rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [PDIV_NUM_W-1:0] num;
      logic [PDIV_DEN_W-1:0] den;
      pside_type             side;
   } pdiv_req_type;

   typedef struct packed {
      logic                  valid;
      logic [PDIV_NUM_W-1:0] quo;
      pside_type             side;
   } pdiv_rsp_type;

endpackage

FILE: rtl/bpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
module bpc_div #(
   parameter int NUM_W  = 32,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic [NUM_W-1:0]  valid_ff;
   logic [NUM_W-1:0]  valid_in;
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_in  [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [NUM_W-1:0]  nq_in   [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [DEN_W-1:0]  den_in  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic [SIDE_W-1:0] side_in [NUM_W];

   always_comb begin
      logic [DEN_W-1:0] rem_prev;
      logic [NUM_W-1:0] nq_prev;
      logic [DEN_W:0]   trial;
      logic             fits;
      for (int s = 0; s < NUM_W; s++) begin
         if (s == 0) begin
            valid_in[s] = in_valid;
            rem_prev    = '0;
            nq_prev     = in_num;
            den_in[s]   = in_den;
            side_in[s]  = in_side;
         end else begin
            valid_in[s] = valid_ff[s-1];
            rem_prev    = rem_ff[s-1];
            nq_prev     = nq_ff[s-1];
            den_in[s]   = den_ff[s-1];
            side_in[s]  = side_ff[s-1];
         end
         trial     = {rem_prev, nq_prev[NUM_W-1]};
         fits      = (trial >= {1'b0, den_in[s]});
         rem_in[s] = fits ? DEN_W'(trial - {1'b0, den_in[s]}) : trial[DEN_W-1:0];
         nq_in[s]  = {nq_prev[NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NUM_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            nq_ff[s]   <= nq_in[s];
            den_ff[s]  <= den_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

FILE: rtl/bpc_front.sv
// Front stages: first temperature term and the operands of the temperature divide.
module bpc_front import bpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [15:0]  in_ut,
   input  logic [23:0]  in_raw_p,
   input  logic [1:0]   in_oss,
   input  coeff_type    coeffs,
   output tdiv_req_type div_req
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [16:0] diff1_ff, diff1_in;
   logic        [23:0] up1_ff, up1_in, up2_ff, up3_ff;
   logic        [1:0]  oss1_ff, oss2_ff, oss3_ff;
   logic signed [33:0] prod2_ff, prod2_in;
   logic signed [18:0] x1_3_ff, x1_3_in;
   logic signed [19:0] d3_ff, d3_in;
   logic signed [26:0] num_s;
   logic [TDIV_NUM_W-1:0] num4_ff, num4_in;
   logic [TDIV_DEN_W-1:0] den4_ff, den4_in;
   tside_type          side4_ff, side4_in;

   assign diff1_in = signed'({1'b0, in_ut}) - signed'({1'b0, coeffs.ac6});
   assign up1_in   = in_raw_p >> (4'd8 - 4'(in_oss));
   assign prod2_in = 34'(diff1_ff) * 34'(signed'({1'b0, coeffs.ac5}));
   assign x1_3_in  = signed'(prod2_ff[33:15]);
   assign d3_in    = 20'(x1_3_in) + 20'(coeffs.md);

   assign num_s    = 27'(coeffs.mc) <<< 11;
   assign num4_in  = num_s[26] ? TDIV_NUM_W'(-num_s) : TDIV_NUM_W'(num_s);
   assign den4_in  = d3_ff[19] ? TDIV_DEN_W'(-d3_ff) : TDIV_DEN_W'(d3_ff);

   always_comb begin
      side4_in.x1  = x1_3_ff;
      side4_in.up  = up3_ff;
      side4_in.oss = oss3_ff;
      side4_in.neg = num_s[26] ^ d3_ff[19];
      side4_in.err = (d3_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff1_ff <= diff1_in;
         up1_ff   <= up1_in;
         oss1_ff  <= in_oss;
         prod2_ff <= prod2_in;
         up2_ff   <= up1_ff;
         oss2_ff  <= oss1_ff;
         x1_3_ff  <= x1_3_in;
         d3_ff    <= d3_in;
         up3_ff   <= up2_ff;
         oss3_ff  <= oss2_ff;
         num4_ff  <= num4_in;
         den4_ff  <= den4_in;
         side4_ff <= side4_in;
      end
   end

   always_comb begin
      div_req.valid = v4_ff;
      div_req.num   = num4_ff;
      div_req.den   = den4_ff;
      div_req.side  = side4_ff;
   end

endmodule

FILE: rtl/bpc_mid.sv
// Middle stages: temperature result and the pressure terms up to the pressure divide.
module bpc_mid import bpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  tdiv_rsp_type div_rsp,
   input  coeff_type    coeffs,
   output pdiv_req_type div_req
);

   logic [7:0] v_ff, v_in;

   logic signed [27:0] q28, x2;
   logic signed [28:0] b5a_ff, b5a_in;
   logic signed [28:0] b6b_ff, b6b_in, t_round;
   logic signed [24:0] t_q;
   logic signed [15:0] tb_ff, tb_in, tc_ff, td_ff, te_ff, tf_ff, tg_ff, th_ff;
   logic signed [57:0] sqc_ff, sqc_in;
   logic signed [44:0] ac2c_ff, ac2c_in;
   logic signed [46:0] ac3c_ff, ac3c_in;
   logic        [45:0] sq12;
   logic        [44:0] b2d_ff, b2d_in;
   logic        [49:0] b1d_ff, b1d_in;
   logic        [33:0] a2d_ff, a3d_ff;
   logic        [33:0] x3ae_ff, x3ae_in, x3be_ff, x3be_in;
   logic        [33:0] b3_sum, x3_round;
   logic        [33:0] b3sf_ff, b3sf_in;
   logic        [31:0] u4f_ff, u4f_in;
   logic        [31:0] b4_prod;
   logic        [16:0] b4g_ff, b4h_ff;
   logic        [31:0] ddg_ff, ddg_in;
   logic        [15:0] b7_scale;
   logic        [31:0] b7h_ff, b7h_in;
   logic        [23:0] upa_ff, upb_ff, upc_ff, upd_ff, upe_ff, upf_ff;
   logic        [1:0]  ossa_ff, ossb_ff, ossc_ff, ossd_ff, osse_ff, ossf_ff, ossg_ff;
   logic        [7:0]  err_ff;
   pside_type          side_out;

   assign v_in = {v_ff[6:0], div_rsp.valid};

   assign q28     = signed'({1'b0, div_rsp.quo});
   assign x2      = div_rsp.side.neg ? -q28 : q28;
   assign b5a_in  = 29'(div_rsp.side.x1) + 29'(x2);

   assign b6b_in  = b5a_ff - B6_OFFSET;
   assign t_round = b5a_ff + T_ROUND;
   assign t_q     = t_round[28:4];

   always_comb begin
      if (t_q > T_MAX) begin
         tb_in = 16'sh7FFF;
      end else if (t_q < T_MIN) begin
         tb_in = -16'sh8000;
      end else begin
         tb_in = t_q[15:0];
      end
   end

   assign sqc_in  = 58'(b6b_ff) * 58'(b6b_ff);
   assign ac2c_in = 45'(coeffs.ac2) * 45'(b6b_ff);
   assign ac3c_in = 47'(coeffs.ac3) * 47'(b6b_ff);

   assign sq12    = sqc_ff[57:12];
   assign b2d_in  = 45'(45'(coeffs.b2) * 45'(signed'({1'b0, sq12})));
   assign b1d_in  = 50'(50'(coeffs.b1) * 50'(signed'({1'b0, sq12})));

   assign x3ae_in = b2d_ff[44:11] + a2d_ff;
   assign x3be_in = a3d_ff + b1d_ff[49:16];

   assign b3_sum   = (34'(coeffs.ac1) <<< 2) + x3ae_ff;
   assign b3sf_in  = (b3_sum << osse_ff) + 34'd2;
   assign x3_round = x3be_ff + 34'd2;
   assign u4f_in   = x3_round[33:2] + B4_OFFSET;

   assign b4_prod  = 32'(coeffs.ac4) * u4f_ff;
   assign ddg_in   = 32'(upf_ff) - b3sf_ff[33:2];

   assign b7_scale = B7_SCALE >> ossg_ff;
   assign b7h_in   = ddg_ff * 32'(b7_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b5a_ff  <= b5a_in;
         upa_ff  <= div_rsp.side.up;
         ossa_ff <= div_rsp.side.oss;
         err_ff  <= {err_ff[6:0], div_rsp.side.err};
         b6b_ff  <= b6b_in;
         tb_ff   <= tb_in;
         upb_ff  <= upa_ff;
         ossb_ff <= ossa_ff;
         sqc_ff  <= sqc_in;
         ac2c_ff <= ac2c_in;
         ac3c_ff <= ac3c_in;
         tc_ff   <= tb_ff;
         upc_ff  <= upb_ff;
         ossc_ff <= ossb_ff;
         b2d_ff  <= b2d_in;
         b1d_ff  <= b1d_in;
         a2d_ff  <= ac2c_ff[44:11];
         a3d_ff  <= ac3c_ff[46:13];
         td_ff   <= tc_ff;
         upd_ff  <= upc_ff;
         ossd_ff <= ossc_ff;
         x3ae_ff <= x3ae_in;
         x3be_ff <= x3be_in;
         te_ff   <= td_ff;
         upe_ff  <= upd_ff;
         osse_ff <= ossd_ff;
         b3sf_ff <= b3sf_in;
         u4f_ff  <= u4f_in;
         tf_ff   <= te_ff;
         upf_ff  <= upe_ff;
         ossf_ff <= osse_ff;
         b4g_ff  <= b4_prod[31:15];
         ddg_ff  <= ddg_in;
         tg_ff   <= tf_ff;
         ossg_ff <= ossf_ff;
         b7h_ff  <= b7h_in;
         b4h_ff  <= b4g_ff;
         th_ff   <= tg_ff;
      end
   end

   // The divide error of the pressure path joins the temperature one here.
   always_comb begin
      side_out.t   = th_ff;
      side_out.hi  = b7h_ff[31];
      side_out.err = err_ff[7] | (b4h_ff == '0);
   end

   always_comb begin
      div_req.valid = v_ff[7];
      div_req.num   = b7h_ff[31] ? b7h_ff : {b7h_ff[30:0], 1'b0};
      div_req.den   = b4h_ff;
      div_req.side  = side_out;
   end

endmodule

FILE: rtl/bpc_back.sv
// Back stages: final pressure correction, saturation and the result register.
module bpc_back import bpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  pdiv_rsp_type       div_rsp,
   output logic               out_valid,
   output logic signed [15:0] out_temp,
   output logic [17:0]        out_press,
   output logic               out_err
);

   logic [3:0] v_ff;
   logic [2:0] err_ff;
   logic signed [15:0] ta_ff, tb_ff, tc_ff;
   logic signed [31:0] pv, pva_ff, pvb_ff;
   logic signed [23:0] pv_hi;
   logic signed [47:0] asqa_ff, asqa_in;
   logic signed [45:0] ma_ff, ma_in;
   logic signed [59:0] quad;
   logic signed [43:0] x1b_ff;
   logic signed [29:0] x2b_ff;
   logic signed [45:0] corr_sum, fin_in, fin_ff;
   logic signed [15:0] temp_ff, temp_in;
   logic        [17:0] press_ff, press_in;
   logic               err_out_ff;

   assign pv      = div_rsp.side.hi ? {div_rsp.quo[30:0], 1'b0} : div_rsp.quo;
   assign pv_hi   = pv[31:8];
   assign asqa_in = 48'(pv_hi) * 48'(pv_hi);
   assign ma_in   = 46'(pv) * PLIN_GAIN;

   assign quad     = 60'(asqa_ff) * PSQ_GAIN;
   assign corr_sum = 46'(x1b_ff) + 46'(x2b_ff) + PRES_OFFSET;
   assign fin_in   = 46'(pvb_ff) + (corr_sum >>> 4);

   always_comb begin
      if (err_ff[2]) begin
         temp_in  = '0;
         press_in = '0;
      end else begin
         temp_in = tc_ff;
         if (fin_ff[45]) begin
            press_in = '0;
         end else if (fin_ff > P_MAX) begin
            press_in = '1;
         end else begin
            press_in = fin_ff[17:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[2:0], div_rsp.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         asqa_ff    <= asqa_in;
         ma_ff      <= ma_in;
         pva_ff     <= pv;
         ta_ff      <= div_rsp.side.t;
         err_ff     <= {err_ff[1:0], div_rsp.side.err};
         x1b_ff     <= quad[59:16];
         x2b_ff     <= ma_ff[45:16];
         pvb_ff     <= pva_ff;
         tb_ff      <= ta_ff;
         fin_ff     <= fin_in;
         tc_ff      <= tb_ff;
         temp_ff    <= temp_in;
         press_ff   <= press_in;
         err_out_ff <= err_ff[2];
      end
   end

   assign out_valid = v_ff[3];
   assign out_temp  = temp_ff;
   assign out_press = press_ff;
   assign out_err   = err_out_ff;

endmodule

FILE: rtl/baro_pressure_temp_compensation_top.sv
// Top level of the barometric pressure and temperature compensation pipeline.
// Each item passes the two bit-serial divider pipelines (27 and 32 stages) plus 16
// arithmetic stages before its result appears.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits and the calibration registers to zero.
module baro_pressure_temp_compensation_top import bpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // raw_temperature, raw_pressure_bytes, oversampling
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // temperature_tenths, pressure_pa
   output logic                  rsp_tuser,  // divide_error
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [63:0]        coef_a_ff, coef_b_ff;
   logic [47:0]        coef_c_ff;
   coeff_type          coeffs;
   logic               en;
   tdiv_req_type       tdiv_req;
   tdiv_rsp_type       tdiv_rsp;
   pdiv_req_type       pdiv_req;
   pdiv_rsp_type       pdiv_rsp;
   logic signed [15:0] out_temp;
   logic [17:0]        out_press;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_COEFFS_A: coef_a_ff <= csr_wr_data;
            CSR_COEFFS_B: coef_b_ff <= csr_wr_data;
            CSR_COEFFS_C: coef_c_ff <= csr_wr_data[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coeffs.ac1 = coef_a_ff[63:48];
      coeffs.ac2 = coef_a_ff[47:32];
      coeffs.ac3 = coef_a_ff[31:16];
      coeffs.ac4 = coef_a_ff[15:0];
      coeffs.ac5 = coef_b_ff[63:48];
      coeffs.ac6 = coef_b_ff[47:32];
      coeffs.b1  = coef_b_ff[31:16];
      coeffs.b2  = coef_b_ff[15:0];
      coeffs.mc  = coef_c_ff[31:16];
      coeffs.md  = coef_c_ff[15:0];
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   bpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_ut    (req_tdata[15:0]),
      .in_raw_p (req_tdata[39:16]),
      .in_oss   (req_tdata[41:40]),
      .coeffs   (coeffs),
      .div_req  (tdiv_req)
   );

   bpc_div #(
      .NUM_W  (TDIV_NUM_W),
      .DEN_W  (TDIV_DEN_W),
      .SIDE_W ($bits(tside_type))
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (tdiv_req.valid),
      .in_num    (tdiv_req.num),
      .in_den    (tdiv_req.den),
      .in_side   (tdiv_req.side),
      .out_valid (tdiv_rsp.valid),
      .out_quo   (tdiv_rsp.quo),
      .out_side  (tdiv_rsp.side)
   );

   bpc_mid u_mid (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_rsp (tdiv_rsp),
      .coeffs  (coeffs),
      .div_req (pdiv_req)
   );

   bpc_div #(
      .NUM_W  (PDIV_NUM_W),
      .DEN_W  (PDIV_DEN_W),
      .SIDE_W ($bits(pside_type))
   ) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pdiv_req.valid),
      .in_num    (pdiv_req.num),
      .in_den    (pdiv_req.den),
      .in_side   (pdiv_req.side),
      .out_valid (pdiv_rsp.valid),
      .out_quo   (pdiv_rsp.quo),
      .out_side  (pdiv_rsp.side)
   );

   bpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .div_rsp   (pdiv_rsp),
      .out_valid (rsp_tvalid),
      .out_temp  (out_temp),
      .out_press (out_press),
      .out_err   (rsp_tuser)
   );

   assign rsp_tdata = {6'b0, out_press, out_temp};

endmodule

FILE: rtl/bpc_checker.sv
// Port-level checks of the compensation pipeline, bound to its top level.
module bpc_checker import bpc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  csr_wr_en,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [CSR_DATA_W-1:0] csr_wr_data
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("divide error with non-zero results");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input refused with empty output");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline stalled");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind baro_pressure_temp_compensation_top bpc_checker u_bpc_checker (.*);

FILE: dv/baro_pressure_temp_compensation_top_tb.sv
// Self-checking testbench for the barometric pressure and temperature compensation pipeline.
`timescale 1ns / 100ps

module baro_pressure_temp_compensation_top_tb;
   import bpc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [15:0] raw_temp;
      logic [23:0] raw_press;
      logic [1:0]  oss;
   } sample_type;

   typedef struct {
      logic signed [15:0] temp_tenths;
      logic [17:0]        press_pa;
      logic               div_err;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   logic [63:0] coef_a = '0;
   logic [63:0] coef_b = '0;
   logic [47:0] coef_c = '0;

   sample_type  pending_samples[$];
   reading_type expected_readings[$];
   sample_type  sample_on_bus;
   int          mismatches = 0;
   bit          gaps_on = 1'b1;
   int          req_gap = 0;
   int          rsp_gap = 0;

   baro_pressure_temp_compensation_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic reading_type compensate(input sample_type s);
      longint      ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint      ut, x1, x2, x3, b5, b6, b3, t, sq, pv, fin, tmp;
      logic [31:0] up, a4, bb, prod, b4, b7, pu;
      reading_type r;
      r.temp_tenths = '0;
      r.press_pa = '0;
      r.div_err = 1'b1;
      ac1 = longint'($signed(coef_a[63:48]));
      ac2 = longint'($signed(coef_a[47:32]));
      ac3 = longint'($signed(coef_a[31:16]));
      ac4 = longint'(coef_a[15:0]);
      ac5 = longint'(coef_b[63:48]);
      ac6 = longint'(coef_b[47:32]);
      b1  = longint'($signed(coef_b[31:16]));
      b2  = longint'($signed(coef_b[15:0]));
      mc  = longint'($signed(coef_c[31:16]));
      md  = longint'($signed(coef_c[15:0]));
      ut  = longint'(s.raw_temp);
      up  = {8'd0, s.raw_press} >> (8 - s.oss);
      x1 = ((ut - ac6) * ac5) >>> 15;
      if (x1 + md == 0) return r;
      x2 = (mc * 2048) / (x1 + md);
      b5 = x1 + x2;
      t  = (b5 + 8) >>> 4;
      b6 = b5 - 4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      x3 = x1 + x2;
      b3 = (((ac1 * 4 + x3) <<< s.oss) + 2) >>> 2;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      tmp  = x3 + 32768;
      a4   = 32'(ac4);
      bb   = 32'(tmp);
      prod = a4 * bb;
      b4   = prod >> 15;
      if (b4 == 0) return r;
      b7 = (up - 32'(b3)) * (32'd50000 >> s.oss);
      if (b7 < 32'h8000_0000) pu = (b7 << 1) / b4;
      else pu = (b7 / b4) << 1;
      pv  = longint'($signed(pu));
      x1  = (pv >>> 8) * (pv >>> 8);
      x1  = (x1 * 3038) >>> 16;
      x2  = (-7357 * pv) >>> 16;
      fin = pv + ((x1 + x2 + 3791) >>> 4);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (fin < 0) fin = 0;
      if (fin > 262143) fin = 262143;
      r.temp_tenths = 16'(t);
      r.press_pa = 18'(fin);
      r.div_err = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      logic       next_valid;
      sample_type s;
      next_valid = req_tvalid;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(compensate(sample_on_bus));
            next_valid = 1'b0;
            req_gap = pick_gap();
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_samples.size() > 0) begin
               s = pending_samples.pop_front();
               sample_on_bus = s;
               req_tdata <= {6'd0, s.oss, s.raw_press, s.raw_temp};
               next_valid = 1'b1;
            end
         end
         req_tvalid <= next_valid;
      end
   end

   always @(posedge clock) begin
      reading_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            end else begin
               e = expected_readings.pop_front();
               if (rsp_tdata[15:0] !== e.temp_tenths || rsp_tdata[33:16] !== e.press_pa
                   || rsp_tdata[39:34] !== 6'd0 || rsp_tuser !== e.div_err) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected t %0d p %0d err %b, got t %0d p %0d err %b",
                              e.temp_tenths, e.press_pa, e.div_err,
                              $signed(rsp_tdata[15:0]), rsp_tdata[33:16], rsp_tuser);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_gap = pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_COEFFS_A) coef_a = value;
      else if (idx == CSR_COEFFS_B) coef_b = value;
      else if (idx == CSR_COEFFS_C) coef_c = value[47:0];
   endtask

   task automatic load_coeffs(input logic [63:0] a, input logic [63:0] b, input logic [63:0] c);
      write_csr(CSR_COEFFS_A, a);
      write_csr(CSR_COEFFS_B, b);
      write_csr(CSR_COEFFS_C, c);
   endtask

   task automatic queue_sample(input logic [15:0] ut, input logic [23:0] p, input logic [1:0] o);
      sample_type s;
      s.raw_temp = ut;
      s.raw_press = p;
      s.oss = o;
      pending_samples.push_back(s);
   endtask

   task automatic queue_random(input int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 9);
         if (roll < 6)
            queue_sample(16'($urandom_range(20000, 32000)), 24'($urandom_range(
                         24'h500000, 24'hB00000)), 2'($urandom));
         else
            queue_sample(16'($urandom), 24'($urandom), 2'($urandom));
      end
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || req_tvalid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      logic [63:0] typ_a, typ_b, typ_c;
      typ_a = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
      typ_b = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
      typ_c = {16'h0000, -16'sd32768, -16'sd8711, 16'sd2868};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // All coefficients zero after reset: the temperature divisor is zero.
      queue_sample(16'd27898, 24'h5D2300, 2'd0);
      queue_sample(16'hFFFF, 24'hFFFFFF, 2'd3);
      drain();

      load_coeffs(typ_a, typ_b, typ_c);
      write_csr(CSR_SPARE, 64'($urandom) << 32 | 64'($urandom));
      queue_sample(16'd27898, 24'h5D2300, 2'd0);
      queue_sample(16'd27898, 24'h5D2300, 2'd1);
      queue_sample(16'd27898, 24'h5D2300, 2'd2);
      queue_sample(16'd27898, 24'h5D2300, 2'd3);
      queue_sample(16'd0, 24'd0, 2'd0);
      queue_sample(16'd0, 24'hFFFFFF, 2'd3);
      queue_sample(16'hFFFF, 24'd0, 2'd3);
      queue_sample(16'hFFFF, 24'hFFFFFF, 2'd0);
      queue_sample(16'h8000, 24'h800000, 2'd2);
      queue_sample(16'h7FFF, 24'h7FFFFF, 2'd1);
      queue_sample(16'd23153, 24'h600000, 2'd1);
      queue_random(150);
      drain();

      // Temperature divisor zero when the raw temperature equals AC6 and MD is zero.
      load_coeffs(typ_a, typ_b, {16'h0000, -16'sd8711, 16'sd0});
      queue_sample(16'd23153, 24'h5D2300, 2'd0);
      queue_sample(16'd23154, 24'h5D2300, 2'd0);
      queue_random(60);
      drain();

      // Pressure divisor zero with AC4 cleared.
      load_coeffs({typ_a[63:16], 16'd0}, typ_b, typ_c);
      queue_sample(16'd27898, 24'h5D2300, 2'd2);
      queue_random(60);
      drain();

      gaps_on = 1'b0;
      load_coeffs('1, '1, '1);
      queue_random(150);
      drain();

      gaps_on = 1'b1;
      load_coeffs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
      queue_random(150);
      drain();

      load_coeffs({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
      queue_random(100);
      drain();

      load_coeffs(typ_a, typ_b, typ_c);
      queue_random(250);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         gaps_on = (ph != 2);
         load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
         queue_random(110);
         drain();
      end

      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("baro_pressure_temp_compensation_top_tb: clean");
      end else begin
         $display("baro_pressure_temp_compensation_top_tb: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("baro_pressure_temp_compensation_top_tb: errors");
      $finish;
   end

endmodule
